// ----- rtl/ius_pkg.sv -----
package ius_pkg;

  localparam int unsigned MaxWidth   = 2048;
  localparam int unsigned RowLimit   = 4096;
  localparam int unsigned ColW       = $clog2(MaxWidth);
  localparam int unsigned RowW       = $clog2(RowLimit);
  localparam int unsigned WidthRegW  = 12;
  localparam int unsigned HeightRegW = 13;
  localparam int unsigned OutRowW    = 13;
  localparam int unsigned OutColW    = 12;
  localparam int unsigned ChanW      = 8;
  localparam int unsigned NumChan    = 3;
  localparam int unsigned PixW       = NumChan * ChanW;
  localparam int unsigned NumSlot    = 4;
  localparam int unsigned SlotW      = $clog2(NumSlot);
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 13;

  localparam int unsigned ChRed   = 2;
  localparam int unsigned ChGreen = 1;
  localparam int unsigned ChBlue  = 0;

  localparam logic [SlotW-1:0] SlotDiag = SlotW'(0);
  localparam logic [SlotW-1:0] SlotUp   = SlotW'(1);
  localparam logic [SlotW-1:0] SlotLeft = SlotW'(2);
  localparam logic [SlotW-1:0] SlotSelf = SlotW'(3);

  typedef enum logic [CfgIdxW-1:0] {
    RegSrcWidth  = CfgIdxW'(0),
    RegSrcHeight = CfgIdxW'(1)
  } cfg_reg_e;

  typedef logic [NumChan-1:0][ChanW-1:0] pix_t;

  typedef struct packed {
    logic [NumSlot-1:0] mask;
    logic [RowW-1:0]    row;
    logic [ColW-1:0]    col;
    logic               fend;
  } ius_load_t;

endpackage

// ----- rtl/ius_ram.sv -----
module ius_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/ius_lane.sv -----
module ius_lane import ius_pkg::*; (
  input  logic [ChanW-1:0] left_i,
  input  logic [ChanW-1:0] ul_i,
  input  logic [ChanW-1:0] above_i,
  input  logic [ChanW-1:0] pix_i,
  output logic [ChanW-1:0] diag_o,
  output logic [ChanW-1:0] up_o,
  output logic [ChanW-1:0] cur_o
);

  function automatic logic [ChanW-1:0] avg(input logic [ChanW-1:0] a,
                                           input logic [ChanW-1:0] b);
    logic [ChanW:0]   s;
    logic [ChanW-1:0] q;
    s = {1'b0, a} + {1'b0, b};
    q = s[ChanW:1];
    if (s[0] && q[0]) begin
      q = q + 1'b1;
    end
    return q;
  endfunction

  logic [ChanW-1:0] hup;

  assign hup    = avg(ul_i, above_i);
  assign cur_o  = avg(left_i, pix_i);
  assign diag_o = avg(hup, cur_o);
  assign up_o   = avg(above_i, pix_i);

endmodule

// ----- rtl/ius_merge.sv -----
module ius_merge import ius_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  ius_load_t          ctrl_i,
  input  pix_t               diag_i,
  input  pix_t               up_i,
  input  pix_t               cur_i,
  input  pix_t               pix_i,
  output logic               free_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [OutRowW-1:0] out_row_o,
  output logic [OutColW-1:0] out_col_o,
  output logic [ChanW-1:0]   red_out_o,
  output logic [ChanW-1:0]   green_out_o,
  output logic [ChanW-1:0]   blue_out_o,
  output logic               run_last_o,
  output logic               frame_end_o
);

  logic [NumSlot-1:0] mask_q, mask_d, mask_pop, sel_bit;
  ius_load_t          ctrl_q;
  pix_t [NumSlot-1:0] slot_q;
  logic [SlotW-1:0]   sel;
  logic               pop, load;
  logic [OutRowW-1:0] row2;
  logic [OutColW-1:0] col2;

  always_comb begin
    sel = SlotSelf;
    for (int i = NumSlot - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        sel = SlotW'(i);
      end
    end
  end

  assign sel_bit     = NumSlot'(1) << sel;
  assign out_valid_o = |mask_q;
  assign pop         = out_valid_o && !out_stall_i;
  assign mask_pop    = pop ? (mask_q & ~sel_bit) : mask_q;
  assign free_o      = (mask_pop == '0);
  assign load        = load_i && free_o;
  assign mask_d      = load ? ctrl_i.mask : mask_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else begin
      mask_q <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ctrl_q           <= ctrl_i;
      slot_q[SlotDiag] <= diag_i;
      slot_q[SlotUp]   <= up_i;
      slot_q[SlotLeft] <= cur_i;
      slot_q[SlotSelf] <= pix_i;
    end
  end

  assign row2 = OutRowW'({ctrl_q.row, 1'b0});
  assign col2 = OutColW'({ctrl_q.col, 1'b0});

  assign out_row_o   = (sel == SlotDiag || sel == SlotUp) ? row2 - 1'b1 : row2;
  assign out_col_o   = (sel == SlotDiag || sel == SlotLeft) ? col2 - 1'b1 : col2;
  assign red_out_o   = slot_q[sel][ChRed];
  assign green_out_o = slot_q[sel][ChGreen];
  assign blue_out_o  = slot_q[sel][ChBlue];
  assign run_last_o  = (sel == SlotSelf);
  assign frame_end_o = run_last_o && ctrl_q.fend;

endmodule

// ----- rtl/image_upscale_2x_linear_unit.sv -----
// Path: an accepted pixel is registered in stage one, then loaded into the merge slots.
// Throughput: one result per cycle unless out_stall_i holds it; a pixel makes 1 to 4
//   results (4 in the interior), drained by the single output port from the result slots.
// Reset: asynchronous, active low; clears counters, handshake state and neighbor pixels,
//   sets src_width to 2048 and src_height to 4096. The row store is not cleared.
module image_upscale_2x_linear_unit import ius_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [ChanW-1:0]    red_in_i,
  input  logic [ChanW-1:0]    green_in_i,
  input  logic [ChanW-1:0]    blue_in_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [OutRowW-1:0]  out_row_o,
  output logic [OutColW-1:0]  out_col_o,
  output logic [ChanW-1:0]    red_out_o,
  output logic [ChanW-1:0]    green_out_o,
  output logic [ChanW-1:0]    blue_out_o,
  output logic                run_last_o,
  output logic                frame_end_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic [WidthRegW-1:0]  src_width_q;
  logic [HeightRegW-1:0] src_height_q;
  logic [ColW-1:0]       col_q;
  logic [RowW-1:0]       row_q;
  pix_t                  left_q, ul_q;
  logic                  s1_v_q;
  pix_t                  s1_pix_q, s1_left_q;
  logic [RowW-1:0]       s1_row_q;
  logic [ColW-1:0]       s1_col_q;
  logic                  s1_fend_q;

  logic [ColW:0]         w_eff;
  logic [RowW:0]         h_eff;
  logic                  col_last, row_last;
  logic                  in_acc, cfg_acc, s1_adv, m_free;
  pix_t                  pix_in, above, diag, up, cur;
  ius_load_t             load_ctrl;

  assign pix_in[ChRed]   = red_in_i;
  assign pix_in[ChGreen] = green_in_i;
  assign pix_in[ChBlue]  = blue_in_i;

  always_comb begin
    if (src_width_q == '0) begin
      w_eff = (ColW + 1)'(1);
    end else if (32'(src_width_q) > MaxWidth) begin
      w_eff = (ColW + 1)'(MaxWidth);
    end else begin
      w_eff = (ColW + 1)'(src_width_q);
    end
    if (src_height_q == '0) begin
      h_eff = (RowW + 1)'(1);
    end else if (32'(src_height_q) > RowLimit) begin
      h_eff = (RowW + 1)'(RowLimit);
    end else begin
      h_eff = (RowW + 1)'(src_height_q);
    end
  end

  assign col_last = ((ColW + 1)'(col_q) + (ColW + 1)'(1)) == w_eff;
  assign row_last = ((RowW + 1)'(row_q) + (RowW + 1)'(1)) == h_eff;

  assign s1_adv      = s1_v_q && m_free;
  assign in_stall_o  = s1_v_q && !m_free;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = !s1_v_q && !out_valid_o;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q  <= WidthRegW'(MaxWidth);
      src_height_q <= HeightRegW'(RowLimit);
      col_q        <= '0;
      row_q        <= '0;
      s1_v_q       <= 1'b0;
      left_q       <= '0;
      ul_q         <= '0;
    end else begin
      if (cfg_acc) begin
        unique case (cfg_reg_e'(cfg_index_i))
          RegSrcWidth: begin
            src_width_q <= cfg_data_i[WidthRegW-1:0];
            col_q       <= '0;
            row_q       <= '0;
          end
          RegSrcHeight: begin
            src_height_q <= cfg_data_i[HeightRegW-1:0];
            col_q        <= '0;
            row_q        <= '0;
          end
          default: ;
        endcase
      end else if (in_acc) begin
        if (col_last) begin
          col_q <= '0;
          row_q <= row_last ? '0 : row_q + 1'b1;
        end else begin
          col_q <= col_q + 1'b1;
        end
      end
      if (in_acc) begin
        left_q <= pix_in;
        s1_v_q <= 1'b1;
      end else if (s1_adv) begin
        s1_v_q <= 1'b0;
      end
      if (s1_adv) begin
        ul_q <= above;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_pix_q  <= pix_in;
      s1_left_q <= left_q;
      s1_row_q  <= row_q;
      s1_col_q  <= col_q;
      s1_fend_q <= col_last && row_last;
    end
  end

  ius_ram #(
    .Width(PixW),
    .Depth(MaxWidth)
  ) u_row_store (
    .clk_i  (clk_i),
    .we_i   (in_acc),
    .waddr_i(col_q),
    .wdata_i(pix_in),
    .re_i   (in_acc),
    .raddr_i(col_q),
    .rdata_o(above)
  );

  for (genvar ch = 0; ch < NumChan; ch++) begin : g_lane
    ius_lane u_lane (
      .left_i (s1_left_q[ch]),
      .ul_i   (ul_q[ch]),
      .above_i(above[ch]),
      .pix_i  (s1_pix_q[ch]),
      .diag_o (diag[ch]),
      .up_o   (up[ch]),
      .cur_o  (cur[ch])
    );
  end

  always_comb begin
    load_ctrl                = '0;
    load_ctrl.mask[SlotDiag] = (s1_row_q != '0) && (s1_col_q != '0);
    load_ctrl.mask[SlotUp]   = (s1_row_q != '0);
    load_ctrl.mask[SlotLeft] = (s1_col_q != '0);
    load_ctrl.mask[SlotSelf] = 1'b1;
    load_ctrl.row            = s1_row_q;
    load_ctrl.col            = s1_col_q;
    load_ctrl.fend           = s1_fend_q;
  end

  ius_merge u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (s1_v_q),
    .ctrl_i     (load_ctrl),
    .diag_i     (diag),
    .up_i       (up),
    .cur_i      (cur),
    .pix_i      (s1_pix_q),
    .free_o     (m_free),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_row_o  (out_row_o),
    .out_col_o  (out_col_o),
    .red_out_o  (red_out_o),
    .green_out_o(green_out_o),
    .blue_out_o (blue_out_o),
    .run_last_o (run_last_o),
    .frame_end_o(frame_end_o)
  );

`ifndef ASSERT_OFF
  a_accept_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> s1_v_q)
    else $error("accepted transaction did not reach stage one");

  a_adv_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_o && (out_row_o[0] == 1'b1 || out_col_o[0] == 1'b1 || run_last_o))
    else $error("stage one advance produced no result");

  a_fend_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_end_o |-> run_last_o)
    else $error("frame end on a result that is not the last of its pixel");

  a_last_even_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && run_last_o |-> !out_row_o[0] && !out_col_o[0])
    else $error("last result of a pixel not at an even position");
`endif

endmodule
